FILE: rtl/core/safq_pkg.sv
// Shared types and constants for the slot allocator with free-slot queue.
// Used by the controller, the datapath and the top level.
package safq_pkg;

  // Store geometry
  localparam int SLOTS      = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = SLOT_W + 1;

  // Request kinds (tuser of the input word)
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Response status codes (tuser of the output word)
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic execute;  // apply the request and load the response
  } cmd_t;

endpackage

FILE: rtl/core/safq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module safq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/safq_ctrl.sv
// Request sequencer: accept, execute, respond.
// Depends on safq_pkg for the command struct.
module safq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output safq_pkg::cmd_t cmd
);
  import safq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready    = (state == ST_IDLE);
  assign m_tvalid    = (state == ST_RESP);
  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.execute = (state == ST_EXEC);

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One request in flight at a time
  a_exec_follows_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.execute)
    else $error("execute did not follow capture");
  a_resp_follows_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> m_tvalid)
    else $error("response did not follow execute");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a response is pending");

endmodule

FILE: rtl/core/safq_dp.sv
// Datapath: occupancy map, high-water count, free-slot queue and value store.
// Depends on safq_pkg and safq_ram.
module safq_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  safq_pkg::cmd_t                 cmd,
  input  logic [1:0]                     in_req_type,
  input  logic [safq_pkg::SLOT_W-1:0]    in_slot_index,
  input  logic [safq_pkg::ELEM_WIDTH-1:0] in_entry_value,
  output logic [safq_pkg::SLOT_W-1:0]    result_slot,
  output logic [1:0]                     status,
  output logic                           is_occupied
);
  import safq_pkg::*;

  // Captured request
  logic [1:0]            req_kind;
  logic [SLOT_W-1:0]     req_slot;
  logic [ELEM_WIDTH-1:0] req_value;

  // Control state
  logic [SLOTS-1:0]  occ_map;
  logic [SLOTS-1:0]  occ_map_next;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] head_next;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] tail_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W-1:0]  hw;
  logic [CNT_W-1:0]  hw_next;

  // Response values
  logic [SLOT_W-1:0] res_slot_next;
  logic [1:0]        res_status_next;
  logic              res_occ_next;

  // Memory ports
  logic [SLOT_W-1:0] q_rd_data;
  logic              q_we;
  logic              st_we;
  logic [SLOT_W-1:0] st_addr;

  // Free-slot queue: read address tracks the head, so the head entry
  // is ready in the cycle after the request is accepted.
  safq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_free_q (
    .clk     (clk),
    .we      (q_we),
    .wr_addr (tail),
    .wr_data (req_slot),
    .rd_addr (head),
    .rd_data (q_rd_data)
  );

  // Value store, written by add only
  safq_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(SLOTS)) u_store (
    .clk     (clk),
    .we      (st_we),
    .wr_addr (st_addr),
    .wr_data (req_value),
    .rd_addr (st_addr),
    .rd_data ()
  );

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= in_req_type;
      req_slot  <= in_slot_index;
      req_value <= in_entry_value;
    end
  end

  // Request execution
  always_comb begin
    occ_map_next    = occ_map;
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    hw_next         = hw;
    res_slot_next   = req_slot;
    res_status_next = STAT_OK;
    res_occ_next    = 1'b0;
    q_we            = 1'b0;
    st_we           = 1'b0;
    st_addr         = hw[SLOT_W-1:0];
    priority if (req_kind == REQ_ADD) begin
      priority if (fill != '0) begin
        // reuse oldest freed slot
        st_addr   = q_rd_data;
        head_next = head + 1'b1;
        fill_next = fill - 1'b1;
        st_we     = cmd.execute;
      end else if (hw < CNT_W'(SLOTS)) begin
        // hand out a fresh slot
        st_addr = hw[SLOT_W-1:0];
        hw_next = hw + 1'b1;
        st_we   = cmd.execute;
      end else begin
        st_addr = '0;
      end
      if (st_we) begin
        occ_map_next[st_addr] = 1'b1;
        res_slot_next         = st_addr;
        res_occ_next          = 1'b1;
      end else begin
        res_slot_next   = '0;
        res_status_next = STAT_FULL;
      end
    end else if (req_kind == REQ_REMOVE) begin
      if (!occ_map[req_slot]) begin
        res_status_next = STAT_EMPTY;
      end else begin
        occ_map_next[req_slot] = 1'b0;
        // the top slot below the count is not queued
        if ((({1'b0, req_slot} + 1'b1) < hw) && (fill != CNT_W'(SLOTS))) begin
          q_we      = cmd.execute;
          tail_next = tail + 1'b1;
          fill_next = fill + 1'b1;
        end
      end
    end else begin
      // query, and the unused code answered as a query
      res_occ_next = occ_map[req_slot];
    end
  end

  // Control state update
  always_ff @(posedge clk) begin
    if (rst) begin
      occ_map <= '0;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      hw      <= '0;
    end else if (cmd.execute) begin
      occ_map <= occ_map_next;
      head    <= head_next;
      tail    <= tail_next;
      fill    <= fill_next;
      hw      <= hw_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      result_slot <= res_slot_next;
      status      <= res_status_next;
      is_occupied <= res_occ_next;
    end
  end

  // Queued slots all lie below the high-water count
  a_fill_le_hw: assert property (@(posedge clk) disable iff (rst)
    fill <= hw)
    else $error("free queue holds more slots than were handed out");
  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    hw <= CNT_W'(SLOTS))
    else $error("high-water count past capacity");
  a_ring_ptrs: assert property (@(posedge clk) disable iff (rst)
    tail == SLOT_W'(head + fill[SLOT_W-1:0]))
    else $error("queue pointers disagree with fill count");
  a_add_marks: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && req_kind == REQ_ADD) |=> (status == STAT_FULL || occ_map[result_slot]))
    else $error("added slot not marked occupied");

endmodule

FILE: rtl/core/slot_allocator_with_free_fifo.sv
// Slot allocator with a queue of freed slots. Each request word carries a
// kind in tuser (add, remove, query) and gives exactly one response word.
// An add takes the oldest freed slot, else the next never-used slot, else
// answers full; a remove clears a slot's mark and queues it for reuse unless
// it is the top slot below the high-water count. One request is handled at a
// time: the accept, then an execute state for the registered read of the
// free-queue RAM and the state update, then a response state. The response
// word is valid once the execute state has passed, and s_tready stays low
// until it is taken, so holding m_tready low delays the next request. The
// state is ready at once after reset; no clearing pass.
// Depends on safq_pkg, safq_ctrl, safq_dp and safq_ram.
module slot_allocator_with_free_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [5:0] slot_index, [37:6] entry_value, [39:38] zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] result_slot, [6] is_occupied, [7] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import safq_pkg::*;

  cmd_t              cmd;
  logic [SLOT_W-1:0] result_slot;
  logic [1:0]        status;
  logic              is_occupied;

  // Sequencer
  safq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Allocation state and store
  safq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_req_type    (s_tuser),
    .in_slot_index  (s_tdata[SLOT_W-1:0]),
    .in_entry_value (s_tdata[SLOT_W +: ELEM_WIDTH]),
    .result_slot    (result_slot),
    .status         (status),
    .is_occupied    (is_occupied)
  );

  // Output word packing
  assign m_tdata = {1'b0, is_occupied, result_slot};
  assign m_tuser = status;

endmodule
